### sv/cdzp_pkg.sv
// ----------------------------------------------------------------------------
// cdzp_pkg
// Shared types and constants for the zero-padded 2-D convolution block.
// ----------------------------------------------------------------------------
package cdzp_pkg;

    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + COEF_W + 1;
    localparam int SUM_W   = 40;
    localparam int IDX_W   = 7;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_COEF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIXEL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic [IDX_W-1:0]         coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic [PIX_W-1:0]         pixel_value;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] out_value;
        logic [COORD_W-1:0]      out_row;
        logic [COORD_W-1:0]      out_col;
        logic                    last;
    } result_t;

    // control bundle fed to every window cell
    typedef struct packed {
        logic shift_en;
        logic cap_en;
    } cell_ctl_t;

endpackage

### sv/conv2d_zero_padded_window.sv
// Output path: cell product regs, then row-sum regs, then the result reg.
// Throughput: one item per cycle; line RAMs and the cell row all advance
//   on each stream step, so nothing holds the stream but result backpressure.
// Reset: counters, window cells and coefficients clear; image_width = 1024
//   (or MAX_WIDTH if smaller). Line RAM contents are not cleared.
// ----------------------------------------------------------------------------
// conv2d_zero_padded_window
// Streaming (2R+1)x(2R+1) convolution of a square image with zero padding.
// ----------------------------------------------------------------------------
module conv2d_zero_padded_window #(
    parameter int RADIUS_TAPS = 1,
    parameter int MAX_WIDTH   = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  cdzp_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output cdzp_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cdzp_pkg::CFG_W-1:0]  cfg_data
);
    import cdzp_pkg::*;

    localparam int KSIDE  = 2 * RADIUS_TAPS + 1;
    localparam int KTAPS  = KSIDE * KSIDE;
    localparam int NLINES = 2 * RADIUS_TAPS;
    localparam int NW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_WIDTH + RADIUS_TAPS + 2);
    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int LW     = $clog2(RADIUS_TAPS * MAX_WIDTH + RADIUS_TAPS + 1);
    localparam int CMPW   = (NW > CFG_W) ? NW : CFG_W;
    localparam int WIDTH_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

    // ------------------------------------------------------------------
    // Handshakes. The product stage can load whenever it is empty or
    // moving on, so a waiting result never blocks new input on its own.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || result_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign item_ready = rdy1;
    assign cfg_ready  = 1'b1;

    logic acc, cfg_acc;
    assign acc     = item_valid && item_ready;
    assign cfg_acc = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------
    // Frame counters
    // ------------------------------------------------------------------
    logic [NW-1:0] n_reg,      n_next;
    logic [RW-1:0] in_row_reg, in_row_next;
    logic [NW-1:0] in_col_reg, in_col_next;
    logic [NW-1:0] orow_reg,   orow_next;
    logic [NW-1:0] ocol_reg,   ocol_next;
    logic [LW-1:0] lag_cnt_reg, lag_cnt_next;

    logic [LW-1:0]    lag;
    logic             loading, step, emit, emit_step, last_hit;
    logic [PIX_W-1:0] pix;
    logic [CMPW-1:0]  cfg_ext;

    // outputs start once the stream is R lines plus R pixels ahead
    assign lag = LW'(n_reg) * LW'(RADIUS_TAPS) + LW'(RADIUS_TAPS);

    assign loading   = in_row_reg < RW'(n_reg);
    assign step      = acc && ((item.mode == MODE_PIXEL)
                       || ((item.mode == MODE_DRAIN) && !loading));
    assign pix       = ((item.mode == MODE_PIXEL) && loading) ? item.pixel_value : '0;
    assign emit      = (lag_cnt_reg == lag);
    assign emit_step = step && emit;
    assign last_hit  = (orow_reg == n_reg - NW'(1)) && (ocol_reg == n_reg - NW'(1));
    assign cfg_ext   = CMPW'(cfg_data);

    always_comb
    begin
        n_next       = n_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        lag_cnt_next = lag_cnt_reg;
        if (cfg_acc)
        begin
            // clamp to 1..MAX_WIDTH and restart the frame
            if (cfg_ext == '0)
            begin
                n_next = NW'(1);
            end
            else if (cfg_ext > CMPW'(MAX_WIDTH))
            begin
                n_next = NW'(MAX_WIDTH);
            end
            else
            begin
                n_next = NW'(cfg_ext);
            end
            in_row_next  = '0;
            in_col_next  = '0;
            orow_next    = '0;
            ocol_next    = '0;
            lag_cnt_next = '0;
        end
        else if (step)
        begin
            if (in_col_reg == n_reg - NW'(1))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + NW'(1);
            end
            if (!emit)
            begin
                lag_cnt_next = lag_cnt_reg + LW'(1);
            end
            else if (last_hit)
            begin
                in_row_next  = '0;
                in_col_next  = '0;
                orow_next    = '0;
                ocol_next    = '0;
                lag_cnt_next = '0;
            end
            else if (ocol_reg == n_reg - NW'(1))
            begin
                ocol_next = '0;
                orow_next = orow_reg + NW'(1);
            end
            else
            begin
                ocol_next = ocol_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg       <= NW'(WIDTH_RST);
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
            lag_cnt_reg <= '0;
        end
        else
        begin
            n_reg       <= n_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            orow_reg    <= orow_next;
            ocol_reg    <= ocol_next;
            lag_cnt_reg <= lag_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Line delays: window row k sees the stream k lines back. Each RAM is
    // addressed by column; the read runs one step ahead on the next column.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] row_in [KSIDE];

    assign row_in[0] = pix;

    for (genvar j = 0; j < NLINES; j++)
    begin : g_line
        cdzp_line #(.DEPTH(MAX_WIDTH)) u_line (
            .clk   (clk),
            .rst_n (rst_n),
            .we    (step),
            .waddr (in_col_reg[AW-1:0]),
            .raddr (in_col_next[AW-1:0]),
            .wdata (row_in[j]),
            .rdata (row_in[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Window: KSIDE chains of KSIDE cells. Cell (k, c) holds the sample
    // k lines and c pixels behind the newest, i.e. tap dr = R-k, dc = R-c.
    // ------------------------------------------------------------------
    cell_ctl_t                cell_ctl;
    logic [PIX_W-1:0]         win_pix [KSIDE][KSIDE];
    logic signed [PROD_W-1:0] prod    [KSIDE][KSIDE];
    logic                     row_ok  [KSIDE];
    logic                     col_ok  [KSIDE];

    assign cell_ctl.shift_en = step;
    assign cell_ctl.cap_en   = emit_step;

    // zero padding: mask taps that fall outside the image
    for (genvar k = 0; k < KSIDE; k++)
    begin : g_ok
        localparam int D = RADIUS_TAPS - k;
        if (D < 0)
        begin : g_neg
            assign row_ok[k] = orow_reg >= NW'(-D);
            assign col_ok[k] = ocol_reg >= NW'(-D);
        end
        else if (D > 0)
        begin : g_pos
            assign row_ok[k] = ((NW+1)'(orow_reg) + (NW+1)'(D)) < (NW+1)'(n_reg);
            assign col_ok[k] = ((NW+1)'(ocol_reg) + (NW+1)'(D)) < (NW+1)'(n_reg);
        end
        else
        begin : g_mid
            assign row_ok[k] = 1'b1;
            assign col_ok[k] = 1'b1;
        end
    end

    for (genvar k = 0; k < KSIDE; k++)
    begin : g_row
        for (genvar c = 0; c < KSIDE; c++)
        begin : g_col
            localparam int CIDX = KTAPS - 1 - (k * KSIDE + c);
            logic [PIX_W-1:0] cin;
            logic             cwe;

            if (c == 0)
            begin : g_head
                assign cin = row_in[k];
            end
            else
            begin : g_tail
                assign cin = win_pix[k][c-1];
            end

            assign cwe = acc && (item.mode == MODE_COEF)
                         && (item.coef_index == IDX_W'(CIDX));

            cdzp_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cell_ctl),
                .pix_in  (cin),
                .coef_we (cwe),
                .coef_in (item.coef_value),
                .tap_ok  (row_ok[k] && col_ok[c]),
                .pix_out (win_pix[k][c]),
                .prod    (prod[k][c])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output tag travels with the products
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] row1_reg, col1_reg, row2_reg, col2_reg;
    logic               last1_reg, last2_reg;

    always_ff @(posedge clk)
    begin
        if (emit_step)
        begin
            row1_reg  <= COORD_W'(orow_reg);
            col1_reg  <= COORD_W'(ocol_reg);
            last1_reg <= last_hit;
        end
    end

    // ------------------------------------------------------------------
    // Sum: per window row, then across rows into the result register
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] row_sum     [KSIDE];
    logic signed [SUM_W-1:0] row_sum_reg [KSIDE];
    logic signed [SUM_W-1:0] total;
    result_t                 result_reg;

    always_comb
    begin
        for (int k = 0; k < KSIDE; k++)
        begin
            row_sum[k] = '0;
            for (int c = 0; c < KSIDE; c++)
            begin
                row_sum[k] = row_sum[k] + SUM_W'(prod[k][c]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int k = 0; k < KSIDE; k++)
        begin
            total = total + row_sum_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int k = 0; k < KSIDE; k++)
            begin
                row_sum_reg[k] <= row_sum[k];
            end
            row2_reg  <= row1_reg;
            col2_reg  <= col1_reg;
            last2_reg <= last1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            result_reg.out_value <= total;
            result_reg.out_row   <= row2_reg;
            result_reg.out_col   <= col2_reg;
            result_reg.last      <= last2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= emit_step;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign result_valid = v3_reg;
    assign result       = result_reg;

endmodule

### sv/cdzp_ram.sv
// ----------------------------------------------------------------------------
// cdzp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdzp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/cdzp_line.sv
// ----------------------------------------------------------------------------
// cdzp_line
// One image line of delay: RAM addressed by column, with a bypass for a
// read that hits the address written in the same cycle.
// ----------------------------------------------------------------------------
module cdzp_line #(
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic [AW-1:0]                raddr,
    input  logic [cdzp_pkg::PIX_W-1:0]   wdata,
    output logic [cdzp_pkg::PIX_W-1:0]   rdata
);
    import cdzp_pkg::*;

    logic [PIX_W-1:0] ram_q;
    logic             byp_v_reg;
    logic             byp_v_next;
    logic [PIX_W-1:0] byp_data_reg;

    cdzp_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign byp_v_next = we && (waddr == raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_v_reg <= 1'b0;
        end
        else
        begin
            byp_v_reg <= byp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= wdata;
    end

    assign rdata = byp_v_reg ? byp_data_reg : ram_q;

endmodule

### sv/cdzp_cell.sv
// ----------------------------------------------------------------------------
// cdzp_cell
// Window cell: one pixel tap, its coefficient, and a registered product.
// ----------------------------------------------------------------------------
module cdzp_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cdzp_pkg::cell_ctl_t               ctl,
    input  logic [cdzp_pkg::PIX_W-1:0]        pix_in,
    input  logic                              coef_we,
    input  logic signed [cdzp_pkg::COEF_W-1:0] coef_in,
    input  logic                              tap_ok,
    output logic [cdzp_pkg::PIX_W-1:0]        pix_out,
    output logic signed [cdzp_pkg::PROD_W-1:0] prod
);
    import cdzp_pkg::*;

    logic [PIX_W-1:0]         pix_reg;
    logic [PIX_W-1:0]         pix_next;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] coef_next;
    logic signed [PROD_W-1:0] mult;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign pix_next  = ctl.shift_en ? pix_in : pix_reg;
    assign coef_next = coef_we ? coef_in : coef_reg;

    // signed multiply in its own context so the coefficient sign-extends
    assign mult = $signed({1'b0, pix_next}) * coef_reg;

    // product of the window as it stands after this shift; padding taps give 0
    assign prod_next = tap_ok ? mult : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            pix_reg  <= pix_next;
            coef_reg <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign pix_out = pix_reg;
    assign prod    = prod_reg;

endmodule
